/* hw/rtl/sidec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidec_pkg: shared types and constants
// Controller states, the command and status groups between controller and
// datapath, and the ASCII codes of the decimal text.
// ----------------------------------------------------------------------------
package sidec_pkg;

	localparam int CHAR_W  = 6;
	localparam int DIGIT_W = 4;

	// ASCII codes, cut to the six bits that the character port carries.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic emit_shift;
		logic sel_sign;
	} ctrl_cmd_t;

	typedef struct packed {
		logic neg;
		logic conv_last;
		logic top_zero;
		logic left_one;
	} dp_stat_t;

endpackage

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Converts one signed integer into its decimal characters, sign first,
// most significant digit first, with the final character flagged.
//
//   channel   signals                  handshake
//   -------   ----------------------   -------------------------------
//   input     value                    start & !busy takes one beat
//   result    character, last          strobe marks each beat
//
// A number goes through the bit-serial BCD conversion, a minus sign beat if
// it is negative, and the digit scan over NDIG digits; NDIG is the digit
// count of 2^(VALUE_WIDTH-1).
// busy drops in the cycle after the last character; start is taken then.
// Reset clears the sequencer; an item in flight is dropped.
// Results cannot be stalled: each beat stands for exactly one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          strobe,
	output logic [sidec_pkg::CHAR_W-1:0]  character,
	output logic                          last
);

	sidec_pkg::ctrl_cmd_t cmd;
	sidec_pkg::dp_stat_t  stat;

	sidec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.last   (last)
	);

	sidec_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.character (character)
	);

	// A result beat only appears while a number is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("result beat while idle");

	// The minus sign is never the final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == sidec_pkg::CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	// After the last character the unit is free for the next number.
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && last) |=> !busy)
		else $error("still busy after last character");

	// An accepted number never produces a beat in the cycle that follows.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> !strobe)
		else $error("result beat right after accept");

endmodule

/* hw/rtl/sidec_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidec_dp: conversion datapath
// Forms the magnitude, turns it into BCD one bit per cycle (shift and add
// three), then shifts the BCD digits out most significant first.
// ----------------------------------------------------------------------------
module sidec_dp #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [VALUE_WIDTH-1:0]  value,
	input  sidec_pkg::ctrl_cmd_t           cmd,
	output sidec_pkg::dp_stat_t            stat,
	output logic [sidec_pkg::CHAR_W-1:0]   character
);

	// Decimal digits of 2^(VALUE_WIDTH-1): floor((VALUE_WIDTH-1)*log10(2)) + 1.
	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * sidec_pkg::DIGIT_W;
	localparam int BIT_W = $clog2(VALUE_WIDTH);
	localparam int CNT_W = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0]        mag_q;
	logic [BCD_W-1:0]              bcd_q;
	logic [BCD_W-1:0]              bcd_adj;
	logic [BIT_W-1:0]              bit_cnt_q;
	logic [CNT_W-1:0]              dig_left_q;
	logic                          neg_q;
	logic [VALUE_WIDTH-1:0]        value_u;
	logic [VALUE_WIDTH-1:0]        mag_d;
	logic [sidec_pkg::DIGIT_W-1:0] top_digit;

	assign value_u = value;
	// Taken as unsigned, the negation of the most negative value is exact.
	assign mag_d   = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q  <= '0;
			dig_left_q <= '0;
			neg_q      <= 1'b0;
		end else if (cmd.load) begin
			bit_cnt_q  <= '0;
			dig_left_q <= CNT_W'(NDIG);
			neg_q      <= value_u[VALUE_WIDTH-1];
		end else begin
			if (cmd.conv_step) begin
				bit_cnt_q <= bit_cnt_q + BIT_W'(1);
			end
			if (cmd.emit_shift) begin
				dig_left_q <= dig_left_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_d;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (cmd.emit_shift) begin
			bcd_q <= {bcd_q[BCD_W-sidec_pkg::DIGIT_W-1:0], {sidec_pkg::DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: sidec_pkg::DIGIT_W];

	assign stat.neg       = neg_q;
	assign stat.conv_last = (bit_cnt_q == BIT_W'(VALUE_WIDTH - 1));
	assign stat.top_zero  = (top_digit == '0);
	assign stat.left_one  = (dig_left_q == CNT_W'(1));

	assign character = cmd.sel_sign ? sidec_pkg::CHAR_MINUS
	                                : sidec_pkg::CHAR_ZERO + {2'b00, top_digit};

endmodule

/* hw/rtl/sidec_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidec_ctrl: conversion sequencer
// Steps the datapath through load, binary-to-BCD conversion, the sign beat
// for a negative value and the digit scan that drops leading zeros.
// ----------------------------------------------------------------------------
module sidec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  sidec_pkg::dp_stat_t  stat,
	output sidec_pkg::ctrl_cmd_t cmd,
	output logic                 busy,
	output logic                 strobe,
	output logic                 last
);

	sidec_pkg::state_t state_q;
	sidec_pkg::state_t state_d;
	logic              started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sidec_pkg::ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				started_q <= 1'b0;
			end else if (state_q == sidec_pkg::ST_EMIT && strobe) begin
				started_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sidec_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sidec_pkg::ST_CONV;
				end
			end
			sidec_pkg::ST_CONV: begin
				if (stat.conv_last) begin
					state_d = stat.neg ? sidec_pkg::ST_SIGN : sidec_pkg::ST_EMIT;
				end
			end
			sidec_pkg::ST_SIGN: begin
				state_d = sidec_pkg::ST_EMIT;
			end
			sidec_pkg::ST_EMIT: begin
				if (stat.left_one) begin
					state_d = sidec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sidec_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		strobe = 1'b0;
		last   = 1'b0;
		unique case (state_q)
			sidec_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			sidec_pkg::ST_CONV: begin
				cmd.conv_step = 1'b1;
			end
			sidec_pkg::ST_SIGN: begin
				cmd.sel_sign = 1'b1;
				strobe       = 1'b1;
			end
			sidec_pkg::ST_EMIT: begin
				// Leading zeros are shifted away silently; the ones digit always goes out.
				cmd.emit_shift = 1'b1;
				strobe         = started_q | ~stat.top_zero | stat.left_one;
				last           = stat.left_one;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* tb/tb_signed_int_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_unit: regression for the integer-to-text unit
// Sends signed 32-bit integers through the command port: first the edge cases,
// then random values spread over every digit count. Each accepted number is
// turned into its expected character beats, and every strobed beat is checked
// in order against them. Gaps of random length, sometimes none, fall between commands, with occasional bursts.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_unit;

	localparam int VW        = 32;
	localparam int MAX_DIGS  = 10;
	localparam int WDOG_MAX  = 2000;
	localparam int SETTLE    = 60;
	localparam int RAND_NUMS = 380;

	typedef struct {
		logic [sidec_pkg::CHAR_W-1:0] ch;
		logic                         fin;
	} text_beat_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic signed [VW-1:0]         value;
	logic                         strobe;
	logic [sidec_pkg::CHAR_W-1:0] character;
	logic                         last;

	logic signed [VW-1:0] pending_values[$];
	text_beat_t           text_fifo[$];
	bit                   taken;
	int                   gap_left;
	int                   burst_left;
	int                   mismatches;
	int                   idle_cycles;

	signed_int_to_decimal_ascii_unit #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.character(character),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Expected beats for one number: optional minus, then digits from the top.
	function automatic void push_decimal_text(logic [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [3:0]    digs[MAX_DIGS];
		int            n;
		text_beat_t    b;
		n = 0;
		mag = v[VW-1] ? (~v + 1'b1) : v;
		do begin
			digs[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		if (v[VW-1]) begin
			b.ch = sidec_pkg::CHAR_MINUS;
			b.fin = 1'b0;
			text_fifo.push_back(b);
		end
		for (int k = n - 1; k >= 0; k--) begin
			b.ch = sidec_pkg::CHAR_ZERO + sidec_pkg::CHAR_W'(digs[k]);
			b.fin = (k == 0);
			text_fifo.push_back(b);
		end
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 60);
	endfunction

	// Driver: a command stays up until the unit takes it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(start && !taken)) begin
				taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_values.size() > 0) begin
					value <= pending_values.pop_front();
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 9) == 0) begin
						burst_left = $urandom_range(10, 30);
					end else begin
						gap_left = draw_gap();
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes command beats and checks every strobed character beat.
	always @(posedge clk) begin
		text_beat_t exp_b;
		if (arst_n) begin
			idle_cycles++;
			if (strobe) begin
				idle_cycles = 0;
				if (text_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: character %0d last %0b",
							character, last);
				end else begin
					exp_b = text_fifo.pop_front();
					if (character !== exp_b.ch || last !== exp_b.fin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("beat mismatch: character exp %0d got %0d, last exp %0b got %0b",
								exp_b.ch, character, exp_b.fin, last);
					end
				end
			end
			if (start && !busy) begin
				idle_cycles = 0;
				taken = 1'b1;
				push_decimal_text(value);
			end
			if (idle_cycles >= WDOG_MAX) begin
				$display("signed_int_to_decimal_ascii_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic signed [VW-1:0] dir_vals[$];
		longint unsigned      lim;
		longint unsigned      m;
		int                   sel;
		int                   k;
		bit                   neg;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		taken = 1'b0;
		gap_left = 0;
		burst_left = 0;
		mismatches = 0;
		idle_cycles = 0;
		dir_vals = '{0, 1, -1, 5, -5, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
			999999999, -999999999, 1000000000, -1000000000, 2147483646,
			32'sh7fffffff, -32'sh7fffffff, 32'sh80000000};
		foreach (dir_vals[i])
			pending_values.push_back(dir_vals[i]);
		for (int i = 0; i < RAND_NUMS; i++) begin
			sel = $urandom_range(0, 99);
			neg = $urandom_range(0, 1);
			k = $urandom_range(1, MAX_DIGS);
			lim = 1;
			repeat (k) lim = lim * 10;
			if (sel < 40) begin
				pending_values.push_back($urandom);
			end else if (sel < 85) begin
				// Magnitude with a chosen digit count, so short texts are common.
				m = {$urandom, $urandom} % lim;
				if (m > 64'h8000_0000)
					m = m % 64'h8000_0000;
				pending_values.push_back(neg ? -VW'(m) : VW'(m));
			end else begin
				// Around a power of ten, where the digit count changes.
				m = (lim > 64'h8000_0000) ? 64'h8000_0000 : lim;
				if ($urandom_range(0, 1))
					m = m - 1;
				pending_values.push_back(neg ? -VW'(m) : VW'(m));
			end
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_values.size() != 0 || start)
			@(posedge clk);
		while (text_fifo.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && text_fifo.size() == 0)
			$display("signed_int_to_decimal_ascii_unit regression: pass");
		else
			$display("signed_int_to_decimal_ascii_unit regression: fail");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/sidec_pkg.sv
hw/rtl/sidec_dp.sv
hw/rtl/sidec_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
tb/tb_signed_int_to_decimal_ascii_unit.sv
